@@ design/sfifo_pkg.sv @@
// Shared types and constants for the byte FIFO with string end marks.
package sfifo_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 7;

    // most bytes returned by one pop
    localparam logic [LEN_W-1:0] RESULT_LIMIT = 7'd64;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data_byte;
        logic              first_of_chunk;
        logic [LEN_W-1:0]  chunk_length;
        logic              ends_string;
        logic [LEN_W-1:0]  pop_limit;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] byte_out;
        logic              byte_valid;
        logic              byte_is_string_end;
        logic              last;
        logic              accepted;
        logic [LEN_W-1:0]  popped_count;
        logic [LEN_W-1:0]  fill_level;
        logic [LEN_W-1:0]  free_space;
        logic              has_full_string;
    } t_out;

    // classified command passed from front to back
    typedef struct packed {
        logic              is_pop;
        logic [DATA_W-1:0] data_byte;
        logic              first_of_chunk;
        logic [LEN_W-1:0]  chunk_length;
        logic              ends_string;
        logic [LEN_W-1:0]  pop_len;
    } t_cmd;

endpackage

@@ design/sfifo_front.sv @@
// Front end: accepts commands, classifies them and queues them for the back end.
module sfifo_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  sfifo_pkg::t_in    i_in,
    output logic              o_cmd_valid,
    output sfifo_pkg::t_cmd   o_cmd,
    input  logic              i_cmd_take
);

    localparam int QDEPTH = 2;

    sfifo_pkg::t_cmd r_q [QDEPTH];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    sfifo_pkg::t_cmd cmd_new;
    logic            push_q;
    logic            pop_q;

    always_comb begin
        cmd_new.is_pop         = (i_in.mode == sfifo_pkg::MODE_POP);
        cmd_new.data_byte      = i_in.data_byte;
        cmd_new.first_of_chunk = i_in.first_of_chunk;
        cmd_new.chunk_length   = i_in.chunk_length;
        cmd_new.ends_string    = i_in.ends_string;
        // clip the pop request to the result limit up front
        cmd_new.pop_len        = (i_in.pop_limit > sfifo_pkg::RESULT_LIMIT) ?
                                 sfifo_pkg::RESULT_LIMIT : i_in.pop_limit;
    end

    assign o_busy      = (r_cnt == 2'(QDEPTH));
    assign push_q      = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop_q       = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({push_q, pop_q})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push_q) begin
                r_wr <= ~r_wr;
            end
            if (pop_q) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q[r_wr] <= cmd_new;
        end
    end

endmodule

@@ design/sfifo_back.sv @@
// Back end: byte store, pointers, counters and the pop sequencer.
module sfifo_back #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  sfifo_pkg::t_cmd   i_cmd,
    output logic              o_cmd_take,
    output logic              o_strobe,
    output sfifo_pkg::t_out   o_result
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > sfifo_pkg::LEN_W) ? CW : sfifo_pkg::LEN_W;
    localparam int MW = sfifo_pkg::DATA_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    // byte plus end mark per slot
    logic [MW-1:0] r_mem [DEPTH];
    logic [MW-1:0] r_rd_data;

    logic          r_state, n_state;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_strings, n_strings;
    logic          r_drop, n_drop;
    logic [sfifo_pkg::LEN_W-1:0] r_left, n_left;
    logic [sfifo_pkg::LEN_W-1:0] r_popped, n_popped;
    logic            r_strobe, n_strobe;
    sfifo_pkg::t_out r_res, n_res;

    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] free_slots;
    logic [LW-1:0] free_ext;
    logic [LW-1:0] count_ext;
    logic [LW-1:0] clen_ext;
    logic [LW-1:0] plen_ext;
    logic          take_byte;
    logic          pop_end;
    logic          pop_fin;
    logic [sfifo_pkg::LEN_W-1:0] pop_n;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        advance = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign free_slots = CW'(DEPTH) - r_count;
    assign free_ext   = LW'(free_slots);
    assign count_ext  = LW'(r_count);
    assign clen_ext   = LW'(i_cmd.chunk_length);
    assign plen_ext   = LW'(i_cmd.pop_len);
    assign pop_n      = (count_ext < plen_ext) ? sfifo_pkg::LEN_W'(r_count) : i_cmd.pop_len;
    assign pop_end    = r_rd_data[0];
    assign pop_fin    = (r_left == sfifo_pkg::LEN_W'(1)) || pop_end;

    always_comb begin
        n_state    = r_state;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_count    = r_count;
        n_strings  = r_strings;
        n_drop     = r_drop;
        n_left     = r_left;
        n_popped   = r_popped;
        n_strobe   = 1'b0;
        o_cmd_take = 1'b0;
        wr_en      = 1'b0;
        take_byte  = 1'b0;
        rd_addr    = r_rd_ptr;
        n_res      = r_res;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    if (!i_cmd.is_pop) begin
                        if (i_cmd.first_of_chunk) begin
                            n_drop = free_ext < clen_ext;
                        end
                        take_byte = !n_drop && (free_slots != '0);
                        if (take_byte) begin
                            wr_en    = 1'b1;
                            n_wr_ptr = advance(r_wr_ptr);
                            n_count  = r_count + CW'(1);
                            if (i_cmd.ends_string) begin
                                n_strings = r_strings + CW'(1);
                            end
                        end
                        n_strobe = 1'b1;
                        n_res    = '0;
                        n_res.last     = 1'b1;
                        n_res.accepted = take_byte;
                    end else if (pop_n == '0) begin
                        n_strobe = 1'b1;
                        n_res    = '0;
                        n_res.last = 1'b1;
                    end else begin
                        // store read of the head slot is issued this cycle
                        n_left   = pop_n;
                        n_popped = '0;
                        n_state  = ST_POP;
                    end
                end
            end
            ST_POP: begin
                rd_addr   = advance(r_rd_ptr);
                n_rd_ptr  = advance(r_rd_ptr);
                n_count   = r_count - CW'(1);
                if (pop_end && (r_strings != '0)) begin
                    n_strings = r_strings - CW'(1);
                end
                n_left   = r_left - sfifo_pkg::LEN_W'(1);
                n_popped = r_popped + sfifo_pkg::LEN_W'(1);
                n_strobe = 1'b1;
                n_res.byte_out           = r_rd_data[MW-1:1];
                n_res.byte_valid         = 1'b1;
                n_res.byte_is_string_end = pop_end;
                n_res.last               = pop_fin;
                n_res.accepted           = pop_fin && pop_end;
                n_res.popped_count       = n_popped;
                if (pop_fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_res.fill_level      = sfifo_pkg::LEN_W'(n_count);
        n_res.free_space      = sfifo_pkg::LEN_W'(CW'(DEPTH) - n_count);
        n_res.has_full_string = (n_strings != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_strings <= '0;
            r_drop    <= 1'b0;
            r_left    <= '0;
            r_popped  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_count   <= n_count;
            r_strings <= n_strings;
            r_drop    <= n_drop;
            r_left    <= n_left;
            r_popped  <= n_popped;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= {i_cmd.data_byte, i_cmd.ends_string};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

@@ design/byte_fifo_with_string_end_marks.sv @@
// With the queue empty, a push or byteless pop result passes the command queue entry and
// the result register; a pop's first byte also passes the registered read of the byte
// store, then one byte per cycle. Pushes go one per cycle while the queue has room; a pop
// holds the back end until its last byte. A two-entry command queue takes new
// commands while the back end works. Synchronous active-low reset empties the FIFO,
// clears the queue and drops any pop in progress; results cannot be stalled.
module byte_fifo_with_string_end_marks #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sfifo_pkg::t_in    i_in,
    output logic              o_strobe,
    output sfifo_pkg::t_out   o_result
);

    logic            cmd_valid;
    logic            cmd_take;
    sfifo_pkg::t_cmd cmd;

    sfifo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    sfifo_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

@@ design/sfifo_checker.sv @@
// Port-level checks for the byte FIFO, bound to the top level.
module sfifo_checker #(
    parameter int DEPTH = 64
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_strobe,
    input sfifo_pkg::t_out o_result
);

    logic [sfifo_pkg::LEN_W-1:0] occ_sum;

    assign occ_sum = o_result.fill_level + o_result.free_space;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (occ_sum == sfifo_pkg::LEN_W'(DEPTH)))
        else $error("fill plus free does not match depth");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.byte_is_string_end) |-> o_result.last)
        else $error("string end byte not last");

    a_byteless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.byte_valid) |-> o_result.last)
        else $error("byteless result not last");

    a_pop_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.byte_valid && o_result.accepted)
            |-> o_result.byte_is_string_end)
        else $error("pop accepted without string end");

endmodule

bind byte_fifo_with_string_end_marks sfifo_checker #(
    .DEPTH (DEPTH)
) u_sfifo_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

@@ tb/string_fifo_checker.sv @@
// Checker for the byte FIFO with string end marks: predicts results and compares them.
module string_fifo_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  sfifo_pkg::t_in   i_in,
    input  logic             i_strobe,
    input  sfifo_pkg::t_out  i_result,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH = 64;
    localparam int PRINT_CAP  = 60;

    logic [7:0]      byte_mem [FIFO_DEPTH];
    logic            mark_mem [FIFO_DEPTH];
    int              rd_idx;
    int              wr_idx;
    int              held;
    int              done_strings;
    bit              dropping;
    sfifo_pkg::t_out due_results[$];
    int              err_count = 0;
    int              due_count = 0;

    assign o_errors  = err_count;
    assign o_pending = due_count;

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    function automatic sfifo_pkg::t_out make_result(input logic [7:0] b, input logic vld,
                                                    input logic mark, input logic fin,
                                                    input logic acc, input int cnt);
        sfifo_pkg::t_out r;
        r.byte_out           = b;
        r.byte_valid         = vld;
        r.byte_is_string_end = mark;
        r.last               = fin;
        r.accepted           = acc;
        r.popped_count       = 7'(cnt);
        r.fill_level         = 7'(held);
        r.free_space         = 7'(FIFO_DEPTH - held);
        r.has_full_string    = done_strings > 0;
        return r;
    endfunction

    // push stores one byte unless its chunk was refused or the store is full; pop drains up to an end mark or its count
    task automatic apply_fifo_op(input sfifo_pkg::t_in it);
        int   room;
        int   n;
        int   i;
        bit   take;
        bit   fin;
        logic mark;
        logic [7:0] b;
        if (it.mode == sfifo_pkg::MODE_PUSH) begin
            room = FIFO_DEPTH - held;
            if (it.first_of_chunk) begin
                dropping = room < int'(it.chunk_length);
            end
            take = !dropping && room != 0;
            if (take) begin
                byte_mem[wr_idx] = it.data_byte;
                mark_mem[wr_idx] = it.ends_string;
                wr_idx = (wr_idx + 1) % FIFO_DEPTH;
                held++;
                if (it.ends_string) done_strings++;
            end
            due_results.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1, take, 0));
        end else begin
            n = int'(it.pop_limit);
            if (n > held) n = held;
            if (n > int'(sfifo_pkg::RESULT_LIMIT)) n = int'(sfifo_pkg::RESULT_LIMIT);
            if (n == 0) begin
                due_results.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 0));
            end else begin
                for (i = 1; i <= n; i++) begin
                    b    = byte_mem[rd_idx];
                    mark = mark_mem[rd_idx];
                    mark_mem[rd_idx] = 1'b0;
                    rd_idx = (rd_idx + 1) % FIFO_DEPTH;
                    held--;
                    if (mark && done_strings > 0) done_strings--;
                    fin = (i == n) || mark;
                    due_results.push_back(make_result(b, 1'b1, mark, fin, fin && mark, i));
                    if (fin) break;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic check_result(input sfifo_pkg::t_out got);
        sfifo_pkg::t_out want;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        check_field("byte_out", got.byte_out, want.byte_out);
        check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
        check_field("byte_is_string_end", 8'(got.byte_is_string_end),
                    8'(want.byte_is_string_end));
        check_field("last", 8'(got.last), 8'(want.last));
        check_field("accepted", 8'(got.accepted), 8'(want.accepted));
        check_field("popped_count", 8'(got.popped_count), 8'(want.popped_count));
        check_field("fill_level", 8'(got.fill_level), 8'(want.fill_level));
        check_field("free_space", 8'(got.free_space), 8'(want.free_space));
        check_field("has_full_string", 8'(got.has_full_string), 8'(want.has_full_string));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FIFO_DEPTH; k++) begin
                mark_mem[k] = 1'b0;
            end
            rd_idx       = 0;
            wr_idx       = 0;
            held         = 0;
            done_strings = 0;
            dropping     = 1'b0;
            due_results.delete();
        end else begin
            // a result never belongs to a transfer taken at the same edge
            if (i_strobe === 1'b1) check_result(i_result);
            if (i_start === 1'b1 && i_busy === 1'b0) apply_fifo_op(i_in);
        end
        due_count = due_results.size();
    end

endmodule

@@ tb/tb_byte_fifo_with_string_end_marks.sv @@
// Testbench top for the byte FIFO with string end marks: stimulus and verdict.
module tb_byte_fifo_with_string_end_marks;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 350;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    logic            busy;
    sfifo_pkg::t_in  i_in    = '0;
    logic            o_strobe;
    sfifo_pkg::t_out o_result;
    int              errors;
    int              pending;
    int              burst_left = 0;
    int              sent = 0;

    always #10 i_clk = ~i_clk;

    byte_fifo_with_string_end_marks u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    string_fifo_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_in      (i_in),
        .i_strobe  (o_strobe),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    function automatic sfifo_pkg::t_in push_byte(input logic [7:0] d, input logic first,
                                                 input logic [6:0] len, input logic ends);
        sfifo_pkg::t_in it;
        it.mode           = sfifo_pkg::MODE_PUSH;
        it.data_byte      = d;
        it.first_of_chunk = first;
        it.chunk_length   = len;
        it.ends_string    = ends;
        it.pop_limit      = 7'($urandom_range(0, 64));
        return it;
    endfunction

    function automatic sfifo_pkg::t_in pop_req(input logic [6:0] maxl);
        sfifo_pkg::t_in it;
        it.mode           = sfifo_pkg::MODE_POP;
        it.data_byte      = 8'($urandom_range(0, 255));
        it.first_of_chunk = 1'($urandom_range(0, 1));
        it.chunk_length   = 7'($urandom_range(0, 64));
        it.ends_string    = 1'($urandom_range(0, 1));
        it.pop_limit      = maxl;
        return it;
    endfunction

    // bursts of back-to-back transfers separated by random gaps
    task automatic send_item(input sfifo_pkg::t_in it);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        burst_left--;
        sent++;
    endtask

    // total > len gives an overlong chunk that runs into a full store
    task automatic send_chunk(input int len, input int total);
        int   k;
        logic ends;
        for (k = 0; k < total; k++) begin
            if (k == total - 1) ends = $urandom_range(0, 9) < 7;
            else                ends = $urandom_range(0, 11) == 0;
            send_item(push_byte(8'($urandom_range(0, 255)), k == 0,
                                (k == 0) ? 7'(len) : 7'($urandom_range(0, 64)), ends));
        end
    endtask

    task automatic send_pop();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)      send_item(pop_req(7'd0));
        else if (r < 3)  send_item(pop_req(7'd64));
        else if (r == 3) send_item(pop_req(7'($urandom_range(0, 64))));
        else             send_item(pop_req(7'($urandom_range(1, 16))));
    endtask

    initial begin
        int r;
        int len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pops, zero and largest count
        send_item(pop_req(7'd0));
        send_item(pop_req(7'd64));
        // zero-length chunk always fits
        send_item(push_byte(8'hFF, 1'b1, 7'd0, 1'b1));
        send_item(push_byte(8'h00, 1'b1, 7'd3, 1'b0));
        send_item(push_byte(8'h5A, 1'b0, 7'd0, 1'b0));
        send_item(push_byte(8'hA5, 1'b0, 7'd127 & 7'd64, 1'b1));
        send_item(pop_req(7'd0));
        send_item(pop_req(7'd64));
        send_item(pop_req(7'd1));
        send_item(pop_req(7'd64));
        // chunk of exactly the free space, then one too large and its tail
        send_item(push_byte(8'h11, 1'b1, 7'd64, 1'b1));
        send_item(push_byte(8'h22, 1'b1, 7'd64, 1'b0));
        send_item(push_byte(8'h33, 1'b0, 7'd0, 1'b1));
        send_item(push_byte(8'h44, 1'b0, 7'd5, 1'b0));
        send_item(push_byte(8'h55, 1'b1, 7'd2, 1'b0));
        send_item(push_byte(8'h66, 1'b0, 7'd0, 1'b1));
        send_item(pop_req(7'd64));
        send_item(pop_req(7'd64));
        send_item(pop_req(7'd64));
        // bytes without an end mark, popped with a large count
        send_item(push_byte(8'h77, 1'b1, 7'd1, 1'b0));
        send_item(pop_req(7'd64));

        // fill past full once, then drain
        sent = 0;
        send_chunk(0, 70);
        repeat (4) send_item(pop_req(7'd64));

        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 64);
                else                           len = $urandom_range(1, 8);
                send_chunk(len, len);
            end else if (r < 80) begin
                send_pop();
            end else if (r < 84) begin
                send_chunk($urandom_range(0, 8), $urandom_range(40, 70));
            end else begin
                send_item(push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                    7'($urandom_range(0, 64)), 1'($urandom_range(0, 1))));
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[byte_fifo_with_string_end_marks] OK");
        end else begin
            $display("[byte_fifo_with_string_end_marks] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[byte_fifo_with_string_end_marks] ERROR");
        $finish;
    end

endmodule
